// ===== hdl/npcm_pkg.sv =====
// Shared types and constants for the nearest palette color match block.
`timescale 1ns / 1ps
package npcm_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned SqW    = 2 * ChanW;
  localparam int unsigned DistW  = 19;  // 4 * 255^2 = 260100
  localparam int unsigned CountW = 5;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned ColorW = 4;

  localparam logic MODE_WRITE    = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } rgba_t;

  typedef logic [DistW-1:0] dist_t;

  // Travels with each palette read through the scan pipeline.
  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

// ===== hdl/npcm_store.sv =====
// Palette memory: one write port, one registered read port.
`timescale 1ns / 1ps
module npcm_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  npcm_pkg::rgba_t  wr_data_i,
  input  npcm_pkg::tag_t   rd_tag_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output npcm_pkg::tag_t   rd_tag_o,
  output logic [IdxW-1:0]  rd_idx_o,
  output npcm_pkg::rgba_t  rd_data_o
);

  npcm_pkg::rgba_t mem [Depth];
  npcm_pkg::rgba_t rd_data_q;
  npcm_pkg::tag_t  rd_tag_q;
  logic [IdxW-1:0] rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_tag_i.vld) begin
      rd_data_q <= mem[rd_addr_i];
    end
    rd_idx_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q <= '0;
    end else begin
      rd_tag_q <= rd_tag_i;
    end
  end

  assign rd_tag_o  = rd_tag_q;
  assign rd_idx_o  = rd_idx_q;
  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/npcm_dist.sv =====
// Two-stage squared Euclidean distance between the pixel and one palette entry.
`timescale 1ns / 1ps
module npcm_dist #(
  parameter int unsigned IdxW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  npcm_pkg::rgba_t  pix_i,
  input  npcm_pkg::tag_t   tag_i,
  input  logic [IdxW-1:0]  idx_i,
  input  npcm_pkg::rgba_t  entry_i,
  output npcm_pkg::tag_t   tag_o,
  output logic [IdxW-1:0]  idx_o,
  output npcm_pkg::dist_t  dist_o
);

  logic [npcm_pkg::ChanW-1:0] pch [4];
  logic [npcm_pkg::ChanW-1:0] ech [4];
  logic [npcm_pkg::ChanW-1:0] diff [4];
  logic [npcm_pkg::SqW-1:0]   sq_d [4];
  logic [npcm_pkg::SqW-1:0]   sq_q [4];
  npcm_pkg::tag_t             tag1_q, tag2_q;
  logic [IdxW-1:0]            idx1_q, idx2_q;
  npcm_pkg::dist_t            dist_q;

  assign pch[0] = pix_i.red;
  assign pch[1] = pix_i.green;
  assign pch[2] = pix_i.blue;
  assign pch[3] = pix_i.alpha;
  assign ech[0] = entry_i.red;
  assign ech[1] = entry_i.green;
  assign ech[2] = entry_i.blue;
  assign ech[3] = entry_i.alpha;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      diff[k] = (pch[k] > ech[k]) ? (pch[k] - ech[k]) : (ech[k] - pch[k]);
      sq_d[k] = diff[k] * diff[k];
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    dist_q <= npcm_pkg::DistW'(sq_q[0]) + npcm_pkg::DistW'(sq_q[1])
            + npcm_pkg::DistW'(sq_q[2]) + npcm_pkg::DistW'(sq_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  assign tag_o  = tag2_q;
  assign idx_o  = idx2_q;
  assign dist_o = dist_q;

endmodule

// ===== hdl/npcm_ctrl.sv =====
// Sequencer: handshakes, palette count register, scan counter and best-match tracking.
`timescale 1ns / 1ps
module npcm_ctrl #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4,
  parameter int unsigned CntW  = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [npcm_pkg::SlotW-1:0]    entry_index_i,
  input  npcm_pkg::rgba_t               pix_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [npcm_pkg::ColorW-1:0]   color_index_o,
  input  logic                          cfg_we_i,
  input  logic [npcm_pkg::CountW-1:0]   cfg_wdata_i,
  output logic                          wr_en_o,
  output logic [IdxW-1:0]               wr_addr_o,
  output npcm_pkg::rgba_t               pix_o,
  output npcm_pkg::tag_t                rd_tag_o,
  output logic [IdxW-1:0]               rd_addr_o,
  input  npcm_pkg::tag_t                res_tag_i,
  input  logic [IdxW-1:0]               res_idx_i,
  input  npcm_pkg::dist_t               res_dist_i
);

  npcm_pkg::state_e             state_q, state_d;
  logic [npcm_pkg::CountW-1:0]  count_q;
  logic [CntW-1:0]              limit_q, limit_d;
  logic [CntW-1:0]              cnt_q;
  logic                         have_q;
  logic [IdxW-1:0]              best_idx_q;
  npcm_pkg::dist_t              best_dist_q;
  npcm_pkg::rgba_t              pix_q;
  logic                         out_vld_q;
  logic [npcm_pkg::ColorW-1:0]  color_q;
  logic                         start;
  logic                         issue;
  logic                         load;
  logic                         better;
  logic [31:0]                  best_ext;

  // Count beyond the memory depth saturates at the depth.
  assign limit_d = (32'(count_q) > Depth) ? CntW'(Depth) : CntW'(count_q);

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    start      = 1'b0;
    issue      = 1'b0;
    load       = 1'b0;
    case (state_q)
      npcm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (mode_i == npcm_pkg::MODE_CLASSIFY)) begin
          start   = 1'b1;
          state_d = (limit_d == '0) ? npcm_pkg::ST_FINISH : npcm_pkg::ST_SCAN;
        end
      end
      npcm_pkg::ST_SCAN: begin
        issue = (cnt_q < limit_q);
        if (res_tag_i.vld && res_tag_i.last) begin
          state_d = npcm_pkg::ST_FINISH;
        end
      end
      npcm_pkg::ST_FINISH: begin
        if (!out_vld_q || out_ready_i) begin
          load    = 1'b1;
          state_d = npcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = npcm_pkg::ST_IDLE;
      end
    endcase
  end

  // Writes only happen while idle, so no scan read can collide with them.
  assign wr_en_o   = in_valid_i && (state_q == npcm_pkg::ST_IDLE)
                   && (mode_i == npcm_pkg::MODE_WRITE) && (32'(entry_index_i) < Depth);
  assign wr_addr_o = IdxW'(entry_index_i);

  assign rd_tag_o.vld  = issue;
  assign rd_tag_o.last = (cnt_q == (limit_q - CntW'(1)));
  assign rd_addr_o     = cnt_q[IdxW-1:0];
  assign pix_o         = pix_q;

  assign better   = res_tag_i.vld && (!have_q || (res_dist_i < best_dist_q));
  assign best_ext = 32'(best_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= npcm_pkg::ST_IDLE;
      count_q   <= npcm_pkg::CountW'(1);
      limit_q   <= '0;
      cnt_q     <= '0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (start) begin
        limit_q <= limit_d;
        cnt_q   <= '0;
        have_q  <= 1'b0;
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + CntW'(1);
        end
        if (better) begin
          have_q <= 1'b1;
        end
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      pix_q      <= pix_i;
      best_idx_q <= '0;
    end else if (better) begin
      best_idx_q  <= res_idx_i;
      best_dist_q <= res_dist_i;
    end
    if (load) begin
      color_q <= best_ext[npcm_pkg::ColorW-1:0];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign color_index_o = color_q;

endmodule

// ===== hdl/nearest_palette_color_match.sv =====
// A classify transaction scans N palette entries, N being min(palette_count, PALETTE_DEPTH);
// one palette entry is read from the memory per cycle, and the index is given when the scan ends.
// A new pixel is accepted only once the previous scan has finished and its result has been loaded
// into the output register, which waits while that register stays full; palette writes are taken while idle.
// The next transaction is accepted while the previous result waits in the output register.
// Reset: palette_count returns to 1 and control clears; palette contents undefined until written.
`timescale 1ns / 1ps
module nearest_palette_color_match #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [npcm_pkg::SlotW-1:0]   entry_index_i,
  input  logic [npcm_pkg::ChanW-1:0]   red_i,
  input  logic [npcm_pkg::ChanW-1:0]   green_i,
  input  logic [npcm_pkg::ChanW-1:0]   blue_i,
  input  logic [npcm_pkg::ChanW-1:0]   alpha_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [npcm_pkg::ColorW-1:0]  color_index_o,
  input  logic                         cfg_we_i,
  input  logic [npcm_pkg::CountW-1:0]  cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1);

  npcm_pkg::rgba_t  pix_in;
  npcm_pkg::rgba_t  pix;
  npcm_pkg::rgba_t  entry;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  npcm_pkg::tag_t   rd_tag, mem_tag, res_tag;
  logic [IdxW-1:0]  rd_addr, mem_idx, res_idx;
  npcm_pkg::dist_t  res_dist;

  assign pix_in.red   = red_i;
  assign pix_in.green = green_i;
  assign pix_in.blue  = blue_i;
  assign pix_in.alpha = alpha_i;

  npcm_ctrl #(
    .Depth (PALETTE_DEPTH),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .entry_index_i (entry_index_i),
    .pix_i         (pix_in),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .color_index_o (color_index_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .pix_o         (pix),
    .rd_tag_o      (rd_tag),
    .rd_addr_o     (rd_addr),
    .res_tag_i     (res_tag),
    .res_idx_i     (res_idx),
    .res_dist_i    (res_dist)
  );

  npcm_store #(
    .Depth (PALETTE_DEPTH),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (pix_in),
    .rd_tag_i  (rd_tag),
    .rd_addr_i (rd_addr),
    .rd_tag_o  (mem_tag),
    .rd_idx_o  (mem_idx),
    .rd_data_o (entry)
  );

  npcm_dist #(
    .IdxW (IdxW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .tag_i   (mem_tag),
    .idx_i   (mem_idx),
    .entry_i (entry),
    .tag_o   (res_tag),
    .idx_o   (res_idx),
    .dist_o  (res_dist)
  );

endmodule
